>>> hdl/itp_pkg.sv
package itp_pkg;

   localparam int DEF_STACK_DEPTH  = 16;
   localparam int DEF_OPERAND_BITS = 32;

   // Fixed field widths of the stream payloads.
   localparam int CMD_W     = 3;
   localparam int VALUE_W   = 32;
   localparam int OP_W      = 3;
   localparam int KIND_W    = 2;
   localparam int ERR_W     = 2;
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   // Depth of the token queue between front and back.
   localparam int QUEUE_DEPTH = 4;

   // Input token kinds.
   localparam logic [CMD_W-1:0] CMD_OPERAND  = 3'd0;
   localparam logic [CMD_W-1:0] CMD_OPERATOR = 3'd1;
   localparam logic [CMD_W-1:0] CMD_OPEN     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CLOSE    = 3'd3;
   localparam logic [CMD_W-1:0] CMD_END      = 3'd4;

   // Operator codes; the open parenthesis mark shares the stack encoding.
   localparam logic [OP_W-1:0] OP_ADD       = 3'd0;
   localparam logic [OP_W-1:0] OP_SUB       = 3'd1;
   localparam logic [OP_W-1:0] OP_MUL       = 3'd2;
   localparam logic [OP_W-1:0] OP_DIV       = 3'd3;
   localparam logic [OP_W-1:0] OP_POW       = 3'd4;
   localparam logic [OP_W-1:0] OPEN_MARK    = 3'd5;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_OPERAND  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_OPERATOR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR    = 2'd2;

   // Error codes.
   localparam logic [ERR_W-1:0] ERR_OVERFLOW     = 2'd0;
   localparam logic [ERR_W-1:0] ERR_UNMATCHED_CL = 2'd1;
   localparam logic [ERR_W-1:0] ERR_UNMATCHED_OP = 2'd2;

   typedef enum logic [2:0] {
      TOK_OPERAND  = 3'd0,
      TOK_OPERATOR = 3'd1,
      TOK_OPEN     = 3'd2,
      TOK_CLOSE    = 3'd3,
      TOK_END      = 3'd4
   } tok_kind_type;

   typedef struct packed {
      tok_kind_type    kind;
      logic [OP_W-1:0] op;
   } tok_type;

   function automatic logic [2:0] prio(input logic [OP_W-1:0] op);
      logic [2:0] p;
      case (op)
         OP_ADD, OP_SUB: p = 3'd1;
         OP_MUL, OP_DIV: p = 3'd3;
         default:        p = 3'd4;
      endcase
      return p;
   endfunction

endpackage

>>> hdl/itp_front.sv
module itp_front #(
   parameter int OPERAND_BITS = itp_pkg::DEF_OPERAND_BITS,
   parameter int VAL_W = (OPERAND_BITS < itp_pkg::VALUE_W) ? OPERAND_BITS : itp_pkg::VALUE_W
) (
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [itp_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic [itp_pkg::CMD_W-1:0]          req_tuser,
   input  logic                               q_full,
   output logic                               q_wr,
   output itp_pkg::tok_type                   q_tok,
   output logic [VAL_W-1:0]                   q_value
);

   logic [itp_pkg::OP_W-1:0] op_code;
   logic                     keep;

   assign op_code    = req_tdata[itp_pkg::VALUE_W +: itp_pkg::OP_W];
   assign req_tready = !q_full;
   assign q_value    = req_tdata[VAL_W-1:0];

   always_comb begin
      keep       = 1'b1;
      q_tok.op   = op_code;
      q_tok.kind = itp_pkg::TOK_OPERAND;
      unique case (req_tuser)
         itp_pkg::CMD_OPERAND:  q_tok.kind = itp_pkg::TOK_OPERAND;
         itp_pkg::CMD_OPERATOR: begin
            q_tok.kind = itp_pkg::TOK_OPERATOR;
            // Operator codes past power mean nothing and are dropped.
            keep = (op_code <= itp_pkg::OP_POW);
         end
         itp_pkg::CMD_OPEN:     q_tok.kind = itp_pkg::TOK_OPEN;
         itp_pkg::CMD_CLOSE:    q_tok.kind = itp_pkg::TOK_CLOSE;
         itp_pkg::CMD_END:      q_tok.kind = itp_pkg::TOK_END;
         default:               keep = 1'b0;
      endcase
   end

   assign q_wr = req_tvalid && !q_full && keep;

endmodule

>>> hdl/itp_queue.sv
module itp_queue #(
   parameter int OPERAND_BITS = itp_pkg::DEF_OPERAND_BITS,
   parameter int VAL_W = (OPERAND_BITS < itp_pkg::VALUE_W) ? OPERAND_BITS : itp_pkg::VALUE_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr,
   input  itp_pkg::tok_type  wr_tok,
   input  logic [VAL_W-1:0]  wr_value,
   output logic              full,
   input  logic              rd,
   output logic              rd_valid,
   output itp_pkg::tok_type  rd_tok,
   output logic [VAL_W-1:0]  rd_value
);

   localparam int QD  = itp_pkg::QUEUE_DEPTH;
   localparam int QAW = $clog2(QD);
   localparam int QCW = $clog2(QD + 1);

   itp_pkg::tok_type   tok_ff [QD];
   logic [VAL_W-1:0]   val_ff [QD];
   logic [QAW-1:0]     wp_ff, wp_in, rp_ff, rp_in;
   logic [QCW-1:0]     cnt_ff, cnt_in;
   logic               do_wr, do_rd;

   assign full     = (cnt_ff == QCW'(QD));
   assign rd_valid = (cnt_ff != '0);
   assign rd_tok   = tok_ff[rp_ff];
   assign rd_value = val_ff[rp_ff];
   assign do_wr    = wr && !full;
   assign do_rd    = rd && rd_valid;

   always_comb begin
      wp_in  = do_wr ? QAW'(32'(wp_ff) + 1) : wp_ff;
      rp_in  = do_rd ? QAW'(32'(rp_ff) + 1) : rp_ff;
      cnt_in = cnt_ff;
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         tok_ff[wp_ff] <= wr_tok;
         val_ff[wp_ff] <= wr_value;
      end
   end

endmodule

>>> hdl/itp_back.sv
module itp_back #(
   parameter int STACK_DEPTH  = itp_pkg::DEF_STACK_DEPTH,
   parameter int OPERAND_BITS = itp_pkg::DEF_OPERAND_BITS,
   parameter int VAL_W = (OPERAND_BITS < itp_pkg::VALUE_W) ? OPERAND_BITS : itp_pkg::VALUE_W
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   input  itp_pkg::tok_type                 q_tok,
   input  logic [VAL_W-1:0]                 q_value,
   output logic                             q_rd,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [itp_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic [itp_pkg::KIND_W-1:0]       rsp_tuser,
   output logic                             rsp_tlast
);

   localparam int AW = $clog2(STACK_DEPTH);
   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int PAD_W = itp_pkg::RSP_TDATA_W - itp_pkg::VALUE_W - itp_pkg::OP_W
                          - itp_pkg::ERR_W;

   logic [itp_pkg::OP_W-1:0]    stack_mem [STACK_DEPTH];
   logic [CW-1:0]               count_ff, count_in;
   logic [itp_pkg::OP_W-1:0]    top_ff, below_ff;
   logic                        paren_ff, paren_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [itp_pkg::KIND_W-1:0]  kind_ff;
   logic [itp_pkg::VALUE_W-1:0] value_ff;
   logic [itp_pkg::OP_W-1:0]    op_ff;
   logic [itp_pkg::ERR_W-1:0]   err_ff;
   logic                        last_ff;

   logic                        gen, gen_last, done, push, pop, fire, out_free;
   logic [itp_pkg::KIND_W-1:0]  gen_kind;
   logic [itp_pkg::VALUE_W-1:0] gen_value;
   logic [itp_pkg::OP_W-1:0]    gen_op;
   logic [itp_pkg::ERR_W-1:0]   gen_err;
   logic [itp_pkg::OP_W-1:0]    push_code;
   logic                        has_room, pop_op;
   logic [CW-1:0]               ra_full, rb_full;
   logic [AW-1:0]               wa, ra, rb;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign has_room = (count_ff < CW'(STACK_DEPTH));
   assign pop_op   = (count_ff != '0) && (top_ff != itp_pkg::OPEN_MARK) &&
                     (itp_pkg::prio(top_ff) >= itp_pkg::prio(q_tok.op));

   // One stack entry is handled per cycle unless a result waits. The entry
   // below the top is kept alongside so that a token's last result is known.
   always_comb begin
      gen       = 1'b0;
      gen_last  = 1'b0;
      gen_kind  = itp_pkg::KIND_OPERAND;
      gen_value = '0;
      gen_op    = '0;
      gen_err   = '0;
      done      = 1'b0;
      push      = 1'b0;
      pop       = 1'b0;
      push_code = q_tok.op;
      paren_in  = paren_ff;
      if (q_valid) begin
         unique case (q_tok.kind)
            itp_pkg::TOK_OPERAND: begin
               gen       = 1'b1;
               gen_last  = 1'b1;
               gen_value = itp_pkg::VALUE_W'(q_value);
               done      = 1'b1;
            end
            itp_pkg::TOK_OPERATOR: begin
               if (pop_op) begin
                  gen      = 1'b1;
                  gen_kind = itp_pkg::KIND_OPERATOR;
                  gen_op   = top_ff;
                  pop      = 1'b1;
                  gen_last = (count_ff == CW'(1)) || (below_ff == itp_pkg::OPEN_MARK) ||
                             (itp_pkg::prio(below_ff) < itp_pkg::prio(q_tok.op));
               end else if (has_room) begin
                  push = 1'b1;
                  done = 1'b1;
               end else begin
                  gen      = 1'b1;
                  gen_last = 1'b1;
                  gen_kind = itp_pkg::KIND_ERROR;
                  gen_err  = itp_pkg::ERR_OVERFLOW;
                  done     = 1'b1;
               end
            end
            itp_pkg::TOK_OPEN: begin
               push_code = itp_pkg::OPEN_MARK;
               done      = 1'b1;
               if (has_room) begin
                  push = 1'b1;
               end else begin
                  gen      = 1'b1;
                  gen_last = 1'b1;
                  gen_kind = itp_pkg::KIND_ERROR;
                  gen_err  = itp_pkg::ERR_OVERFLOW;
               end
            end
            itp_pkg::TOK_CLOSE: begin
               if (count_ff == '0) begin
                  gen      = 1'b1;
                  gen_last = 1'b1;
                  gen_kind = itp_pkg::KIND_ERROR;
                  gen_err  = itp_pkg::ERR_UNMATCHED_CL;
                  done     = 1'b1;
               end else if (top_ff == itp_pkg::OPEN_MARK) begin
                  pop  = 1'b1;
                  done = 1'b1;
               end else begin
                  gen      = 1'b1;
                  gen_kind = itp_pkg::KIND_OPERATOR;
                  gen_op   = top_ff;
                  pop      = 1'b1;
                  gen_last = (count_ff > CW'(1)) && (below_ff == itp_pkg::OPEN_MARK);
               end
            end
            itp_pkg::TOK_END: begin
               if (count_ff == '0) begin
                  done     = 1'b1;
                  paren_in = 1'b0;
                  if (paren_ff) begin
                     gen      = 1'b1;
                     gen_last = 1'b1;
                     gen_kind = itp_pkg::KIND_ERROR;
                     gen_err  = itp_pkg::ERR_UNMATCHED_OP;
                  end
               end else if (top_ff == itp_pkg::OPEN_MARK) begin
                  pop      = 1'b1;
                  paren_in = 1'b1;
               end else begin
                  gen      = 1'b1;
                  gen_kind = itp_pkg::KIND_OPERATOR;
                  gen_op   = top_ff;
                  pop      = 1'b1;
                  gen_last = (count_ff == CW'(1)) && !paren_ff;
               end
            end
            default: begin
               done = 1'b1;
            end
         endcase
      end
   end

   // A result waits while the output register is still held by the receiver.
   assign fire = !(gen && !out_free);
   assign q_rd = q_valid && done && fire;

   always_comb begin
      count_in = count_ff;
      if (fire && push) begin
         count_in = count_ff + 1'b1;
      end else if (fire && pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign wa      = count_ff[AW-1:0];
   assign ra_full = count_in - CW'(1);
   assign rb_full = count_in - CW'(2);
   assign ra      = ra_full[AW-1:0];
   assign rb      = rb_full[AW-1:0];

   always_ff @(posedge clock) begin
      if (fire && push) begin
         stack_mem[wa] <= push_code;
      end
   end

   // Registered reads of the two top entries, with the push written through.
   always_ff @(posedge clock) begin
      if (fire && push && (wa == ra)) begin
         top_ff <= push_code;
      end else begin
         top_ff <= stack_mem[ra];
      end
      if (fire && push && (wa == rb)) begin
         below_ff <= push_code;
      end else begin
         below_ff <= stack_mem[rb];
      end
   end

   assign rsp_valid_in = (gen && fire) || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         paren_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            paren_ff <= paren_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (gen && fire) begin
         kind_ff  <= gen_kind;
         value_ff <= gen_value;
         op_ff    <= gen_op;
         err_ff   <= gen_err;
         last_ff  <= gen_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, err_ff, op_ff, value_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule

>>> hdl/infix_to_postfix_converter.sv
// Infix to postfix conversion by the shunting-yard method.
// The req channel takes one infix token per beat: tuser carries the token
// kind, tdata the operand value and operator code. The rsp channel returns
// postfix results: operands, operators and errors, with tlast on the final
// result that one token causes. Tokens that cause nothing give no beat.
// A front stage decodes each beat into a four-entry token queue, so req
// keeps accepting a beat every cycle while the queue has room. The back
// stage works the operator stack one entry per cycle while no result waits
// for the output register: an operand is passed on at once, an operator
// pops each stacked operator of equal or higher priority, then is pushed
// or reports overflow; a close parenthesis or end token removes stack
// entries one at a time, then a trailing error or empty check follows.
// The first result of a token is registered once the output register is
// free. The stack memory has registered read ports for its top two entries.
// When rsp_tready is low the output register holds its beat, the back stage
// waits, and req keeps filling the queue until it is full.
// Reset empties the queue, the stack and the output register; no clearing
// pass is needed.
module infix_to_postfix_converter #(
   parameter int STACK_DEPTH  = itp_pkg::DEF_STACK_DEPTH,
   parameter int OPERAND_BITS = itp_pkg::DEF_OPERAND_BITS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [31:0] operand_value, [34:32] op_code, [39:35] zero
   input  logic [itp_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // [2:0] cmd
   input  logic [itp_pkg::CMD_W-1:0]        req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [31:0] out_value, [34:32] out_op, [36:35] error_code, [39:37] zero
   output logic [itp_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // [1:0] out_kind
   output logic [itp_pkg::KIND_W-1:0]       rsp_tuser,
   output logic                             rsp_tlast
);

   localparam int VAL_W = (OPERAND_BITS < itp_pkg::VALUE_W) ? OPERAND_BITS : itp_pkg::VALUE_W;

   logic              q_full, q_wr, q_rd, q_valid;
   itp_pkg::tok_type  wr_tok, rd_tok;
   logic [VAL_W-1:0]  wr_value, rd_value;

   itp_front #(
      .OPERAND_BITS (OPERAND_BITS),
      .VAL_W        (VAL_W)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_wr       (q_wr),
      .q_tok      (wr_tok),
      .q_value    (wr_value)
   );

   itp_queue #(
      .OPERAND_BITS (OPERAND_BITS),
      .VAL_W        (VAL_W)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr       (q_wr),
      .wr_tok   (wr_tok),
      .wr_value (wr_value),
      .full     (q_full),
      .rd       (q_rd),
      .rd_valid (q_valid),
      .rd_tok   (rd_tok),
      .rd_value (rd_value)
   );

   itp_back #(
      .STACK_DEPTH  (STACK_DEPTH),
      .OPERAND_BITS (OPERAND_BITS),
      .VAL_W        (VAL_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_tok      (rd_tok),
      .q_value    (rd_value),
      .q_rd       (q_rd),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int STACK_SLOTS = itp_pkg::DEF_STACK_DEPTH;

   typedef struct {
      logic [itp_pkg::CMD_W-1:0]   cmd;
      logic [itp_pkg::VALUE_W-1:0] value;
      logic [itp_pkg::OP_W-1:0]    op;
   } token_beat_type;

   typedef struct {
      logic [itp_pkg::KIND_W-1:0]  kind;
      logic [itp_pkg::VALUE_W-1:0] value;
      logic [itp_pkg::OP_W-1:0]    op;
      logic [itp_pkg::ERR_W-1:0]   err;
      logic                        last;
   } postfix_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [itp_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [itp_pkg::CMD_W-1:0]       req_tuser  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [itp_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic [itp_pkg::KIND_W-1:0]      rsp_tuser;
   logic                            rsp_tlast;

   token_beat_type   pending_tokens[$];
   postfix_beat_type postfix_expect[$];

   // Own copy of the operator stack, used only for prediction.
   logic [itp_pkg::OP_W-1:0] op_stack[STACK_SLOTS];
   int                       stack_fill = 0;

   int tokens_total    = 0;
   int tokens_accepted = 0;
   int live_tokens     = 0;
   int mismatch_count  = 0;

   infix_to_postfix_converter u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int binding_rank(input logic [itp_pkg::OP_W-1:0] op);
      if (op == itp_pkg::OP_ADD || op == itp_pkg::OP_SUB) return 1;
      if (op == itp_pkg::OP_MUL || op == itp_pkg::OP_DIV) return 3;
      return 4;
   endfunction

   function automatic void emit_result(input logic [itp_pkg::KIND_W-1:0] kind,
                                       input logic [itp_pkg::VALUE_W-1:0] value,
                                       input logic [itp_pkg::OP_W-1:0] op,
                                       input logic [itp_pkg::ERR_W-1:0] err);
      postfix_beat_type b;
      b.kind  = kind;
      b.value = value;
      b.op    = op;
      b.err   = err;
      b.last  = 1'b0;
      postfix_expect.push_back(b);
   endfunction

   function automatic void push_or_overflow(input logic [itp_pkg::OP_W-1:0] code);
      if (stack_fill < STACK_SLOTS) begin
         op_stack[stack_fill] = code;
         stack_fill++;
      end else begin
         emit_result(itp_pkg::KIND_ERROR, '0, '0, itp_pkg::ERR_OVERFLOW);
      end
   endfunction

   // Shunting-yard step: appends every result one token causes.
   function automatic void convert_token(input token_beat_type t);
      int                        first;
      logic [itp_pkg::OP_W-1:0]  top;
      logic                      matched;
      logic                      saw_open;
      postfix_beat_type          tail;
      first = postfix_expect.size();
      case (t.cmd)
         itp_pkg::CMD_OPERAND: begin
            emit_result(itp_pkg::KIND_OPERAND, t.value, '0, '0);
         end
         itp_pkg::CMD_OPERATOR: begin
            if (t.op <= itp_pkg::OP_POW) begin
               while (stack_fill > 0) begin
                  top = op_stack[stack_fill-1];
                  if (top == itp_pkg::OPEN_MARK || binding_rank(top) < binding_rank(t.op))
                     break;
                  emit_result(itp_pkg::KIND_OPERATOR, '0, top, '0);
                  stack_fill--;
               end
               push_or_overflow(t.op);
            end
         end
         itp_pkg::CMD_OPEN: begin
            push_or_overflow(itp_pkg::OPEN_MARK);
         end
         itp_pkg::CMD_CLOSE: begin
            matched = 1'b0;
            while (stack_fill > 0) begin
               top = op_stack[stack_fill-1];
               stack_fill--;
               if (top == itp_pkg::OPEN_MARK) begin
                  matched = 1'b1;
                  break;
               end
               emit_result(itp_pkg::KIND_OPERATOR, '0, top, '0);
            end
            if (!matched)
               emit_result(itp_pkg::KIND_ERROR, '0, '0, itp_pkg::ERR_UNMATCHED_CL);
         end
         itp_pkg::CMD_END: begin
            saw_open = 1'b0;
            while (stack_fill > 0) begin
               top = op_stack[stack_fill-1];
               stack_fill--;
               if (top == itp_pkg::OPEN_MARK) saw_open = 1'b1;
               else emit_result(itp_pkg::KIND_OPERATOR, '0, top, '0);
            end
            if (saw_open)
               emit_result(itp_pkg::KIND_ERROR, '0, '0, itp_pkg::ERR_UNMATCHED_OP);
         end
         default: ;
      endcase
      if (postfix_expect.size() > first) begin
         tail = postfix_expect.pop_back();
         tail.last = 1'b1;
         postfix_expect.push_back(tail);
      end
   endfunction

   task automatic report_mismatch(input string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Driver: presents queued tokens, idling at random.
   always @(posedge clock) begin
      token_beat_type t;
      logic           quiet;
      quiet = (tokens_accepted >= 75 && tokens_accepted < 110);
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            t.cmd   = req_tuser;
            t.value = req_tdata[itp_pkg::VALUE_W-1:0];
            t.op    = req_tdata[itp_pkg::VALUE_W+itp_pkg::OP_W-1:itp_pkg::VALUE_W];
            convert_token(t);
            tokens_accepted <= tokens_accepted + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_tokens.size() > 0 && (quiet || $urandom_range(0, 99) >= 35)) begin
               t = pending_tokens.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= t.cmd;
               req_tdata  <= {{(itp_pkg::REQ_TDATA_W-itp_pkg::VALUE_W-itp_pkg::OP_W){1'b0}},
                              t.op, t.value};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   int hold_left = 0;
   bit hold_done = 1'b0;

   // One long hold-off lets the token queue fill and stall the input.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && tokens_accepted >= 60) begin
         hold_done <= 1'b1;
         hold_left <= 300;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Monitor: checks each result beat and drives the ready side.
   always @(posedge clock) begin
      postfix_beat_type e;
      logic             quiet;
      quiet = (tokens_accepted >= 75 && tokens_accepted < 110);
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (postfix_expect.size() == 0) begin
               report_mismatch($sformatf("unexpected beat kind %0d data %h",
                                         rsp_tuser, rsp_tdata));
            end else begin
               e = postfix_expect.pop_front();
               if (rsp_tuser !== e.kind)
                  report_mismatch($sformatf("kind %0d, wanted %0d", rsp_tuser, e.kind));
               if (rsp_tdata[itp_pkg::VALUE_W-1:0] !== e.value)
                  report_mismatch($sformatf("value %h, wanted %h",
                                            rsp_tdata[itp_pkg::VALUE_W-1:0], e.value));
               if (rsp_tdata[itp_pkg::VALUE_W+itp_pkg::OP_W-1:itp_pkg::VALUE_W] !== e.op)
                  report_mismatch($sformatf("op %0d, wanted %0d",
                     rsp_tdata[itp_pkg::VALUE_W+itp_pkg::OP_W-1:itp_pkg::VALUE_W], e.op));
               if (rsp_tdata[itp_pkg::VALUE_W+itp_pkg::OP_W+itp_pkg::ERR_W-1:
                             itp_pkg::VALUE_W+itp_pkg::OP_W] !== e.err)
                  report_mismatch($sformatf("error code %0d, wanted %0d",
                     rsp_tdata[itp_pkg::VALUE_W+itp_pkg::OP_W+itp_pkg::ERR_W-1:
                               itp_pkg::VALUE_W+itp_pkg::OP_W], e.err));
               if (rsp_tlast !== e.last)
                  report_mismatch($sformatf("tlast %b, wanted %b", rsp_tlast, e.last));
            end
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= quiet || ($urandom_range(0, 99) >= 35);
         end
      end
   end

   task automatic add_token(input logic [itp_pkg::CMD_W-1:0] cmd,
                            input logic [itp_pkg::OP_W-1:0] op,
                            input logic [itp_pkg::VALUE_W-1:0] value);
      token_beat_type t;
      t.cmd   = cmd;
      t.op    = op;
      t.value = value;
      pending_tokens.push_back(t);
      tokens_total++;
      if (cmd <= itp_pkg::CMD_END && !(cmd == itp_pkg::CMD_OPERATOR && op > itp_pkg::OP_POW))
         live_tokens++;
   endtask

   function automatic logic [itp_pkg::VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [itp_pkg::OP_W-1:0] any_op();
      return itp_pkg::OP_W'($urandom_range(0, 7));
   endfunction

   task automatic add_operand();
      add_token(itp_pkg::CMD_OPERAND, any_op(), pick_value());
   endtask

   task automatic add_operator();
      add_token(itp_pkg::CMD_OPERATOR,
                itp_pkg::OP_W'($urandom_range(itp_pkg::OP_ADD, itp_pkg::OP_POW)), $urandom);
   endtask

   // Well-formed infix expression with random nesting.
   task automatic gen_expr(input int level);
      int terms;
      terms = $urandom_range(1, 4);
      for (int i = 0; i < terms; i++) begin
         if (i > 0) add_operator();
         if (level < 3 && $urandom_range(0, 3) == 0) begin
            add_token(itp_pkg::CMD_OPEN, any_op(), $urandom);
            gen_expr(level + 1);
            add_token(itp_pkg::CMD_CLOSE, any_op(), $urandom);
         end else begin
            add_operand();
         end
      end
   endtask

   initial begin
      int random_start;
      int choice;

      // Directed part: every operator with popping by priority and left
      // associativity, operand extremes, parentheses, and unmatched-paren errors.
      add_token(itp_pkg::CMD_OPERAND, 3'd0, 32'h0000_0000);
      add_token(itp_pkg::CMD_OPERATOR, itp_pkg::OP_ADD, 32'h0);
      add_token(itp_pkg::CMD_OPERAND, 3'd7, 32'hFFFF_FFFF);
      add_token(itp_pkg::CMD_OPERATOR, itp_pkg::OP_MUL, 32'h0);
      add_token(itp_pkg::CMD_OPERAND, 3'd0, 32'h8000_0001);
      add_token(itp_pkg::CMD_OPERATOR, itp_pkg::OP_POW, 32'hFFFF_FFFF);
      add_token(itp_pkg::CMD_OPERAND, 3'd0, 32'h1234_5678);
      add_token(itp_pkg::CMD_OPERATOR, itp_pkg::OP_SUB, 32'h0);
      add_token(itp_pkg::CMD_OPERAND, 3'd0, 32'h5555_AAAA);
      add_token(itp_pkg::CMD_OPERATOR, itp_pkg::OP_DIV, 32'h0);
      add_token(itp_pkg::CMD_OPERAND, 3'd0, 32'hAAAA_5555);
      add_token(itp_pkg::CMD_END, 3'd7, 32'hFFFF_FFFF);
      add_token(itp_pkg::CMD_OPEN, 3'd0, 32'h0);
      add_token(itp_pkg::CMD_OPERAND, 3'd0, 32'h0000_0001);
      add_token(itp_pkg::CMD_OPERATOR, itp_pkg::OP_ADD, 32'h0);
      add_token(itp_pkg::CMD_OPERAND, 3'd0, 32'h0000_0002);
      add_token(itp_pkg::CMD_CLOSE, 3'd0, 32'h0);
      add_token(itp_pkg::CMD_OPERATOR, itp_pkg::OP_MUL, 32'h0);
      add_token(itp_pkg::CMD_OPERAND, 3'd0, 32'h0000_0003);
      add_token(itp_pkg::CMD_OPERATOR, itp_pkg::OP_SUB, 32'h0);
      // Close with no open: stacked operators drain, then an error.
      add_token(itp_pkg::CMD_CLOSE, 3'd0, 32'h0);
      // Open left at end, end on an empty stack, and ignored tokens.
      add_token(itp_pkg::CMD_OPEN, 3'd0, 32'h0);
      add_token(itp_pkg::CMD_END, 3'd0, 32'h0);
      add_token(itp_pkg::CMD_END, 3'd0, 32'h0);
      add_token(3'd5, 3'd0, 32'hFFFF_FFFF);
      add_token(3'd7, 3'd7, 32'h0);
      add_token(itp_pkg::CMD_OPERATOR, 3'd5, 32'h0);
      add_token(itp_pkg::CMD_OPERATOR, 3'd7, 32'h0);

      random_start = live_tokens;
      while (live_tokens - random_start < 90) begin
         choice = $urandom_range(0, 9);
         if (choice <= 5) begin
            gen_expr(0);
            add_token(itp_pkg::CMD_END, any_op(), $urandom);
         end else if (choice == 6) begin
            repeat ($urandom_range(1, 4))
               add_token(itp_pkg::CMD_W'($urandom_range(0, 7)), any_op(), $urandom);
         end else if (choice == 7) begin
            // Broken: a stray open or close around a valid expression.
            if ($urandom_range(0, 1)) add_token(itp_pkg::CMD_OPEN, any_op(), $urandom);
            gen_expr(0);
            if ($urandom_range(0, 1)) add_token(itp_pkg::CMD_CLOSE, any_op(), $urandom);
            add_token(itp_pkg::CMD_END, any_op(), $urandom);
         end else if (choice == 8) begin
            // Fill the stack with opens, then overflow on an open or operator.
            repeat (STACK_SLOTS) add_token(itp_pkg::CMD_OPEN, any_op(), $urandom);
            if ($urandom_range(0, 1)) add_token(itp_pkg::CMD_OPEN, any_op(), $urandom);
            else add_operator();
            add_operand();
            add_token(itp_pkg::CMD_END, any_op(), $urandom);
         end else begin
            // Expression without an end: the stack carries into the next one.
            gen_expr(1);
         end
      end
      add_token(itp_pkg::CMD_END, 3'd0, 32'h0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (tokens_accepted < tokens_total) @(posedge clock);
      while (postfix_expect.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("infix_to_postfix_converter test passed");
      end else begin
         $display("infix_to_postfix_converter test failed");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("infix_to_postfix_converter test failed");
      $finish;
   end

endmodule

>>> filelist.f
hdl/itp_pkg.sv
hdl/itp_front.sv
hdl/itp_queue.sv
hdl/itp_back.sv
hdl/infix_to_postfix_converter.sv
sim/tb.sv
